### sv/pcct_pkg.sv
package pcct_pkg;

  localparam int NODE_W  = 7;
  localparam int CMD_W   = 3;
  localparam int DELTA_W = 3;
  localparam int OUT_CNT_W = 16;
  localparam int PROJ_W  = 17;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD   = 3'd0,
    CMD_REM   = 3'd1,
    CMD_QUERY = 3'd2,
    CMD_PROJ  = 3'd3,
    CMD_CLEAR = 3'd4
  } cmd_t;

  localparam logic signed [DELTA_W-1:0] DELTA_POS  = 3'sd2;
  localparam logic signed [DELTA_W-1:0] DELTA_NEG  = -3'sd2;
  localparam logic signed [DELTA_W-1:0] DELTA_NONE = 3'sd0;

  // Decoded command for one beat; the pair checks are already folded in.
  typedef struct packed {
    logic op_add;
    logic op_rem;
    logic op_read;
    logic op_clear;
    logic commit;
  } op_dec_t;

endpackage

### sv/pcct_ram.sv
module pcct_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2016,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                   clk,
  input  logic                   we,
  input  logic [AW-1:0]          waddr,
  input  logic [WIDTH-1:0]       wdata,
  input  logic                   re,
  input  logic [AW-1:0]          raddr,
  output logic [WIDTH-1:0]       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### sv/pcct_addr.sv
module pcct_addr #(
  parameter int NODES = 64,
  localparam int DEPTH = NODES * (NODES - 1) / 2,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic [pcct_pkg::CMD_W-1:0]  command,
  input  logic [pcct_pkg::NODE_W-1:0] node_a,
  input  logic [pcct_pkg::NODE_W-1:0] node_b,
  input  logic                        commit,
  output pcct_pkg::op_dec_t           dec,
  output logic [AW-1:0]               idx
);

  localparam int PW = 2 * pcct_pkg::NODE_W;

  logic [pcct_pkg::NODE_W-1:0] hi;
  logic [pcct_pkg::NODE_W-1:0] lo;
  logic [PW-1:0]               tri_prod;
  logic [PW-1:0]               idx_full;
  logic                        pair_ok;

  always_comb begin
    hi = (node_a > node_b) ? node_a : node_b;
    lo = (node_a > node_b) ? node_b : node_a;
    tri_prod = PW'(hi - 1'b1) * PW'(hi - 2'd2);
    idx_full = (tri_prod >> 1) + PW'(lo) - PW'(1);
    idx = AW'(idx_full);
    pair_ok = (node_a != node_b) && (node_a != '0) && (node_b != '0) &&
              (32'(node_a) <= NODES) && (32'(node_b) <= NODES);
  end

  always_comb begin
    dec = '0;
    dec.commit = commit;
    unique case (pcct_pkg::cmd_t'(command))
      pcct_pkg::CMD_ADD:   dec.op_add   = pair_ok;
      pcct_pkg::CMD_REM:   dec.op_rem   = pair_ok;
      pcct_pkg::CMD_QUERY: dec.op_read  = pair_ok;
      pcct_pkg::CMD_PROJ:  dec.op_read  = pair_ok;
      pcct_pkg::CMD_CLEAR: dec.op_clear = 1'b1;
      default:             dec = '0;
    endcase
  end

endmodule

### sv/pcct_upd.sv
module pcct_upd #(
  parameter int COUNT_WIDTH = 16
) (
  input  pcct_pkg::op_dec_t                   dec,
  input  logic [COUNT_WIDTH-1:0]              cnt,
  output logic [COUNT_WIDTH-1:0]              cnt_new,
  output logic                                wr_en,
  output logic signed [pcct_pkg::DELTA_W-1:0] cost_delta,
  output logic [pcct_pkg::OUT_CNT_W-1:0]      pair_count,
  output logic [pcct_pkg::PROJ_W-1:0]         projected
);

  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;
  localparam logic [COUNT_WIDTH-1:0] CNT_ONE = COUNT_WIDTH'(1);
  localparam logic [COUNT_WIDTH-1:0] CNT_TWO = COUNT_WIDTH'(2);

  logic        any_op;
  logic [31:0] cnt_ext;
  logic [31:0] cnt_m1_ext;

  always_comb begin
    cnt_new    = cnt;
    wr_en      = 1'b0;
    cost_delta = pcct_pkg::DELTA_NONE;
    any_op     = dec.op_add | dec.op_rem | dec.op_read;
    priority if (dec.op_add) begin
      if (dec.commit) begin
        cnt_new    = (cnt == CNT_MAX) ? cnt : cnt + CNT_ONE;
        wr_en      = 1'b1;
        cost_delta = (cnt_new > CNT_ONE) ? pcct_pkg::DELTA_POS : pcct_pkg::DELTA_NONE;
      end else begin
        cost_delta = (cnt != '0) ? pcct_pkg::DELTA_POS : pcct_pkg::DELTA_NONE;
      end
    end else if (dec.op_rem) begin
      if (dec.commit) begin
        cnt_new    = (cnt == '0) ? cnt : cnt - CNT_ONE;
        wr_en      = 1'b1;
        cost_delta = (cnt_new != '0) ? pcct_pkg::DELTA_NEG : pcct_pkg::DELTA_NONE;
      end else begin
        cost_delta = (cnt >= CNT_TWO) ? pcct_pkg::DELTA_NEG : pcct_pkg::DELTA_NONE;
      end
    end else begin
      cnt_new = cnt;
    end
    cnt_ext    = 32'(cnt_new);
    cnt_m1_ext = 32'(cnt_new - CNT_ONE);
    pair_count = any_op ? cnt_ext[pcct_pkg::OUT_CNT_W-1:0] : '0;
    projected  = (any_op && (cnt_new >= CNT_TWO)) ?
                 {cnt_m1_ext[pcct_pkg::PROJ_W-2:0], 1'b0} : '0;
  end

endmodule

### sv/pair_count_cost_table.sv
// Use counts for unordered pairs of distinct nodes 1..NODES, kept in one
// synchronous memory of NODES*(NODES-1)/2 counters.
// Input beats carry a command, two node ids and a commit flag; every input
// beat produces exactly one output beat with cost_delta, pair_count and
// projected. There are no configuration registers.
// An accepted beat reads its table entry at the accepting edge; the block
// then updates the entry and loads the output register, which raises
// out_valid, once that register is free.
// The memory read-modify-write sets the rate: a new beat is accepted only
// once the previous one has left the update stage. in_stall is high while
// a beat is in the update stage, so no two accesses to one entry overlap.
// After reset, and after each clear command, the block sweeps all
// NODES*(NODES-1)/2 entries (2016 at the default of 64 nodes) to zero,
// one entry per cycle, and holds in_stall high meanwhile. A clear
// command's zero result enters the output register as its sweep begins.
// When out_stall holds a result, the next beat may still be accepted and
// read; it waits in the update stage until the output register is free.
module pair_count_cost_table #(
  parameter int NODES = 64,
  parameter int COUNT_WIDTH = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [pcct_pkg::CMD_W-1:0]          in_command,
  input  logic [pcct_pkg::NODE_W-1:0]         in_node_a,
  input  logic [pcct_pkg::NODE_W-1:0]         in_node_b,
  input  logic                                in_commit,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [pcct_pkg::DELTA_W-1:0] out_cost_delta,
  output logic [pcct_pkg::OUT_CNT_W-1:0]      out_pair_count,
  output logic [pcct_pkg::PROJ_W-1:0]         out_projected
);

  localparam int DEPTH = NODES * (NODES - 1) / 2;
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

  pcct_pkg::op_dec_t in_dec;
  logic [AW-1:0]     in_idx;
  logic              in_accept;

  pcct_pkg::op_dec_t s1_dec_r;
  logic [AW-1:0]     s1_idx_r;
  logic              busy_r;
  logic              clearing_r;
  logic [AW-1:0]     clr_addr_r;
  logic              done;

  logic [COUNT_WIDTH-1:0]              rd_cnt;
  logic [COUNT_WIDTH-1:0]              cnt_new;
  logic                                upd_wr;
  logic signed [pcct_pkg::DELTA_W-1:0] delta;
  logic [pcct_pkg::OUT_CNT_W-1:0]      pair_count;
  logic [pcct_pkg::PROJ_W-1:0]         projected;

  logic                   ram_we;
  logic [AW-1:0]          ram_waddr;
  logic [COUNT_WIDTH-1:0] ram_wdata;

  logic                                out_valid_r;
  logic signed [pcct_pkg::DELTA_W-1:0] out_cost_delta_r;
  logic [pcct_pkg::OUT_CNT_W-1:0]      out_pair_count_r;
  logic [pcct_pkg::PROJ_W-1:0]         out_projected_r;

  pcct_addr #(
    .NODES (NODES)
  ) u_addr (
    .command (in_command),
    .node_a  (in_node_a),
    .node_b  (in_node_b),
    .commit  (in_commit),
    .dec     (in_dec),
    .idx     (in_idx)
  );

  assign in_stall  = busy_r | clearing_r;
  assign in_accept = in_valid & ~in_stall;
  assign done      = busy_r & (~out_valid_r | ~out_stall);

  always_comb begin
    ram_we    = clearing_r | (done & upd_wr);
    ram_waddr = clearing_r ? clr_addr_r : s1_idx_r;
    ram_wdata = clearing_r ? '0 : cnt_new;
  end

  pcct_ram #(
    .WIDTH (COUNT_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (in_accept),
    .raddr (in_idx),
    .rdata (rd_cnt)
  );

  pcct_upd #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_upd (
    .dec        (s1_dec_r),
    .cnt        (rd_cnt),
    .cnt_new    (cnt_new),
    .wr_en      (upd_wr),
    .cost_delta (delta),
    .pair_count (pair_count),
    .projected  (projected)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      clearing_r  <= 1'b1;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_accept) begin
        busy_r <= 1'b1;
      end else if (done) begin
        busy_r <= 1'b0;
      end

      if (done && s1_dec_r.op_clear) begin
        clearing_r <= 1'b1;
        clr_addr_r <= '0;
      end else if (clearing_r) begin
        if (clr_addr_r == LAST_ADDR) begin
          clearing_r <= 1'b0;
        end
        clr_addr_r <= clr_addr_r + 1'b1;
      end

      if (done) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_dec_r <= in_dec;
      s1_idx_r <= in_idx;
    end
    if (done) begin
      out_cost_delta_r <= delta;
      out_pair_count_r <= pair_count;
      out_projected_r  <= projected;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_cost_delta = out_cost_delta_r;
  assign out_pair_count = out_pair_count_r;
  assign out_projected  = out_projected_r;

`ifndef SYNTHESIS
  a_sweep_excludes_update: assert property (@(posedge clk) disable iff (!rst_n)
    clearing_r |-> !busy_r)
    else $error("Memory sweep overlaps a pending update.");

  a_accept_sets_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> busy_r)
    else $error("Accepted beat did not enter the update stage.");

  a_result_from_update: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(busy_r))
    else $error("Result appeared without a beat in the update stage.");

  a_sweep_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> clearing_r)
    else $error("Memory sweep did not start after reset.");

  a_clear_starts_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    (done && s1_dec_r.op_clear) |=> (clearing_r && clr_addr_r == '0))
    else $error("Clear command did not restart the memory sweep.");
`endif

endmodule

### verif/pair_count_cost_table_tb.sv
module pair_count_cost_table_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CMD_W     = pcct_pkg::CMD_W;
  localparam int NODE_W    = pcct_pkg::NODE_W;
  localparam int DELTA_W   = pcct_pkg::DELTA_W;
  localparam int OUT_CNT_W = pcct_pkg::OUT_CNT_W;
  localparam int PROJ_W    = pcct_pkg::PROJ_W;

  localparam int NODES   = 64;
  localparam int COUNT_W = 16;
  localparam int PAIRS   = NODES * (NODES - 1) / 2;
  localparam int CNT_MAX = (1 << COUNT_W) - 1;
  localparam int TARGET_REQUESTS = 1900;

  typedef struct packed {
    logic signed [DELTA_W-1:0] delta;
    logic [OUT_CNT_W-1:0]      count;
    logic [PROJ_W-1:0]         proj;
  } pair_reply_t;

  class pair_count_tracker;
    bit [COUNT_W-1:0] counts [PAIRS];
    pair_reply_t      expected_replies [$];
    int               failures;
    int               checked;
    int               clears;
    int               saturated_adds;

    function new();
      foreach (counts[i]) counts[i] = '0;
      failures = 0;
      checked = 0;
      clears = 0;
      saturated_adds = 0;
    endfunction

    function int pending();
      return expected_replies.size();
    endfunction

    function void queue_reply(pair_reply_t r);
      expected_replies.insert(expected_replies.size(), r);
    endfunction

    function void note_request(logic [CMD_W-1:0] cmd, logic [NODE_W-1:0] a,
                               logic [NODE_W-1:0] b, logic commit);
      pair_reply_t r;
      int hi;
      int lo;
      int idx;
      int n;
      bit [COUNT_W-1:0] c;
      r = '0;
      if (cmd == pcct_pkg::CMD_CLEAR) begin
        foreach (counts[i]) counts[i] = '0;
        clears++;
        queue_reply(r);
        return;
      end
      if (cmd > pcct_pkg::CMD_CLEAR || a == b || a == 0 || b == 0 ||
          a > NODES || b > NODES) begin
        queue_reply(r);
        return;
      end
      hi = (a > b) ? a : b;
      lo = (a > b) ? b : a;
      idx = (hi - 1) * (hi - 2) / 2 + (lo - 1);
      c = counts[idx];
      case (cmd)
        pcct_pkg::CMD_ADD: begin
          if (commit) begin
            if (c != CNT_MAX) c++;
            else saturated_adds++;
            counts[idx] = c;
            r.delta = (c > 1) ? pcct_pkg::DELTA_POS : pcct_pkg::DELTA_NONE;
          end else begin
            r.delta = (c >= 1) ? pcct_pkg::DELTA_POS : pcct_pkg::DELTA_NONE;
          end
        end
        pcct_pkg::CMD_REM: begin
          if (commit) begin
            if (c != 0) c--;
            counts[idx] = c;
            r.delta = (c > 0) ? pcct_pkg::DELTA_NEG : pcct_pkg::DELTA_NONE;
          end else begin
            r.delta = (c >= 2) ? pcct_pkg::DELTA_NEG : pcct_pkg::DELTA_NONE;
          end
        end
        default: ;
      endcase
      n = c;
      r.count = OUT_CNT_W'(n);
      r.proj = (n >= 2) ? PROJ_W'((n - 1) * 2) : '0;
      queue_reply(r);
    endfunction

    function void check_reply(pair_reply_t got);
      pair_reply_t exp;
      if (expected_replies.size() == 0) begin
        $error("result beat with no request outstanding: %s %0d %s %0d %s %0d",
               "cost_delta", got.delta, "pair_count", got.count,
               "projected", got.proj);
        failures++;
        return;
      end
      exp = expected_replies.pop_front();
      checked++;
      if (got.delta !== exp.delta) begin
        $error("cost_delta: expected %0d, actual %0d", exp.delta, got.delta);
        failures++;
      end
      if (got.count !== exp.count) begin
        $error("pair_count: expected %0d, actual %0d", exp.count, got.count);
        failures++;
      end
      if (got.proj !== exp.proj) begin
        $error("projected: expected %0d, actual %0d", exp.proj, got.proj);
        failures++;
      end
    endfunction
  endclass

  logic                      clk;
  logic                      rst_n;
  logic                      in_valid;
  logic                      in_stall;
  logic [CMD_W-1:0]          in_command;
  logic [NODE_W-1:0]         in_node_a;
  logic [NODE_W-1:0]         in_node_b;
  logic                      in_commit;
  logic                      out_valid;
  logic                      out_stall;
  logic signed [DELTA_W-1:0] out_cost_delta;
  logic [OUT_CNT_W-1:0]      out_pair_count;
  logic [PROJ_W-1:0]         out_projected;

  pair_count_tracker tracker = new();
  bit  no_gaps;
  int  hot_base;
  int  mix;
  int  requests_sent;
  int  useful_requests;

  pair_count_cost_table #(
    .NODES(NODES),
    .COUNT_WIDTH(COUNT_W)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_command(in_command),
    .in_node_a(in_node_a),
    .in_node_b(in_node_b),
    .in_commit(in_commit),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_cost_delta(out_cost_delta),
    .out_pair_count(out_pair_count),
    .out_projected(out_projected)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("pair_count_cost_table: mismatch");
    $finish;
  end

  task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [NODE_W-1:0] a,
                              input logic [NODE_W-1:0] b, input logic commit);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_command <= cmd;
    in_node_a  <= a;
    in_node_b  <= b;
    in_commit  <= commit;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tracker.note_request(cmd, a, b, commit);
    requests_sent++;
    if (cmd == pcct_pkg::CMD_CLEAR ||
        (cmd < pcct_pkg::CMD_CLEAR && a != b && a != 0 && b != 0 &&
         a <= NODES && b <= NODES))
      useful_requests++;
  endtask

  task automatic wait_until_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  function automatic logic [NODE_W-1:0] pick_node();
    if ($urandom_range(0, 99) < 12) return NODE_W'($urandom_range(0, 127));
    return NODE_W'(hot_base + $urandom_range(0, 3));
  endfunction

  task automatic random_request();
    int r;
    int add_w;
    int rem_w;
    logic [CMD_W-1:0] cmd;
    add_w = (mix == 0) ? 60 : (mix == 1) ? 15 : 35;
    rem_w = (mix == 0) ? 15 : (mix == 1) ? 60 : 35;
    r = $urandom_range(0, 99);
    if (r < add_w) cmd = pcct_pkg::CMD_ADD;
    else if (r < add_w + rem_w) cmd = pcct_pkg::CMD_REM;
    else if (r < 98) cmd = $urandom_range(0, 1) ? pcct_pkg::CMD_QUERY : pcct_pkg::CMD_PROJ;
    else if (r == 98) cmd = CMD_W'($urandom_range(5, 7));
    else cmd = $urandom_range(0, 1) ? pcct_pkg::CMD_CLEAR : pcct_pkg::CMD_QUERY;
    send_request(cmd, pick_node(), pick_node(), $urandom_range(0, 99) < 80);
  endtask

  initial begin
    pair_reply_t got;
    int stall_len;
    out_stall <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall_len = no_gaps ? 0 : $urandom_range(0, 10);
      if (stall_len > 0) begin
        out_stall <= 1'b1;
        repeat (stall_len) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      got.delta = out_cost_delta;
      got.count = out_pair_count;
      got.proj  = out_projected;
      tracker.check_reply(got);
    end
  end

  initial begin
    rst_n      <= 1'b0;
    in_valid   <= 1'b0;
    in_command <= pcct_pkg::CMD_QUERY;
    in_node_a  <= '0;
    in_node_b  <= '0;
    in_commit  <= 1'b0;
    no_gaps = 1'b0;
    hot_base = 1;
    mix = 2;
    requests_sent = 0;
    useful_requests = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    send_request(pcct_pkg::CMD_ADD,   7'd1,  7'd2,  1'b1);
    send_request(pcct_pkg::CMD_ADD,   7'd1,  7'd2,  1'b0);
    send_request(pcct_pkg::CMD_ADD,   7'd2,  7'd1,  1'b1);
    send_request(pcct_pkg::CMD_QUERY, 7'd1,  7'd2,  1'b1);
    send_request(pcct_pkg::CMD_PROJ,  7'd2,  7'd1,  1'b0);
    send_request(pcct_pkg::CMD_REM,   7'd1,  7'd2,  1'b0);
    send_request(pcct_pkg::CMD_REM,   7'd1,  7'd2,  1'b1);
    send_request(pcct_pkg::CMD_REM,   7'd2,  7'd1,  1'b0);
    send_request(pcct_pkg::CMD_REM,   7'd1,  7'd2,  1'b1);
    send_request(pcct_pkg::CMD_REM,   7'd1,  7'd2,  1'b1);
    send_request(pcct_pkg::CMD_ADD,   7'd64, 7'd63, 1'b1);
    send_request(pcct_pkg::CMD_ADD,   7'd63, 7'd64, 1'b1);
    send_request(pcct_pkg::CMD_ADD,   7'd1,  7'd64, 1'b1);
    send_request(pcct_pkg::CMD_ADD,   7'd5,  7'd5,  1'b1);
    send_request(pcct_pkg::CMD_ADD,   7'd0,  7'd3,  1'b1);
    send_request(pcct_pkg::CMD_REM,   7'd65, 7'd2,  1'b1);
    send_request(pcct_pkg::CMD_ADD,   7'd127, 7'd127, 1'b1);
    send_request(CMD_W'(5), 7'd1,  7'd2,  1'b1);
    send_request(CMD_W'(6), 7'd63, 7'd64, 1'b0);
    send_request(CMD_W'(7), 7'd2,  7'd1,  1'b1);
    send_request(pcct_pkg::CMD_PROJ,  7'd64, 7'd63, 1'b0);
    send_request(pcct_pkg::CMD_CLEAR, 7'd0,  7'd0,  1'b1);
    send_request(pcct_pkg::CMD_QUERY, 7'd64, 7'd63, 1'b0);
    wait_until_drained();

    while (requests_sent < TARGET_REQUESTS) begin
      mix = $urandom_range(0, 2);
      no_gaps = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 2))
        0: hot_base = 1;
        1: hot_base = NODES - 3;
        default: hot_base = $urandom_range(1, NODES - 3);
      endcase
      repeat (100) random_request();
      if ($urandom_range(0, 3) == 0) wait_until_drained();
    end
    no_gaps = 1'b0;
    in_valid <= 1'b0;

    while (tracker.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Sent %0d request beats (%0d on valid pairs or clears) and checked %0d results.",
             requests_sent, useful_requests, tracker.checked);
    $display("The table was cleared %0d times and adds hit the counter limit %0d times.",
             tracker.clears, tracker.saturated_adds);
    if (tracker.failures == 0 && tracker.pending() == 0) begin
      $display("pair_count_cost_table: match");
    end else begin
      $display("pair_count_cost_table: mismatch");
    end
    $finish;
  end

endmodule
